// File: rtl/ttfc_pkg.sv
`timescale 1ns / 1ps
// ttfc_pkg: types and constants shared by the thermal throttle fan controller
// no dependencies

package ttfc_pkg;

    localparam int AddrW = 4;
    localparam int DataW = 32;

    localparam logic [7:0]  MaxTempReset  = 8'd75;
    localparam logic [7:0]  FalloffReset  = 8'd5;
    localparam logic [13:0] StartSleep    = 14'd100;
    localparam logic [13:0] MaxSleep      = 14'd9999;
    localparam logic [2:0]  Pauses        = 3'd5;
    localparam logic [16:0] Div3Mul       = 17'd43691;
    localparam logic [12:0] Div100Mul     = 13'd5243;

    typedef enum logic [1:0] {
        RegMaxTemp    = 2'd0,
        RegFalloff    = 2'd1,
        RegFixedFan   = 2'd2,
        RegFanEnable  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] max_temp;
        logic [7:0] falloff;
        logic [6:0] fixed_fan_level;
        logic       fan_control_enable;
    } cfg_t;

endpackage

// File: rtl/ttfc_if.sv
`timescale 1ns / 1ps
// ttfc_meas_if, ttfc_act_if: valid/ready channels of the fan controller
// no dependencies

interface ttfc_meas_if;
    logic       valid;
    logic       ready;
    logic [7:0] temp_c;
    logic [7:0] fan_pwm_in;

    modport source (output valid, output temp_c, output fan_pwm_in, input ready);
    modport sink   (input valid, input temp_c, input fan_pwm_in, output ready);
endinterface

interface ttfc_act_if;
    logic        valid;
    logic        ready;
    logic        fan_write;
    logic        fan_auto;
    logic [7:0]  fan_pwm_out;
    logic        throttle;
    logic [13:0] sleep_ms;
    logic [2:0]  pause_repeats;

    modport source (output valid, output fan_write, output fan_auto, output fan_pwm_out,
                    output throttle, output sleep_ms, output pause_repeats, input ready);
    modport sink   (input valid, input fan_write, input fan_auto, input fan_pwm_out,
                    input throttle, input sleep_ms, input pause_repeats, output ready);
endinterface

// File: rtl/thermal_throttle_fan_controller.sv
`timescale 1ns / 1ps
// thermal_throttle_fan_controller: throttle and fan step control, one item per period
// depends on ttfc_pkg, ttfc_if (ttfc_meas_if, ttfc_act_if) and ttfc_regs
//
// usage
//   meas carries one control period: temperature and the fan pwm read back.
//   act returns one item per period: the last fan command (write, auto, pwm),
//   the throttle flag, pause length in ms and the number of pauses.
//   configuration sits behind the apb port: max_temp, falloff, fixed fan level
//   and fan enable at byte addresses 0, 4, 8 and 12; write only while idle.
// timing
//   an item taken on meas is held in an input register, evaluated in one pass
//   of logic and lands in the output register, which drives act.valid.
//   one item per cycle is sustained while act does not stall; the only loop
//   is the state update (cooling flag, sleep time, last temperature, auto
//   flag), which closes through that one pass of logic.
// reset and stalls
//   reset empties both registers, restores the register defaults and clears
//   the controller state. while act is stalled the output holds its item and
//   one more item is taken into the input register before meas drops ready.

module thermal_throttle_fan_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ttfc_pkg::AddrW-1:0]    paddr,
    input  logic [ttfc_pkg::DataW-1:0]    pwdata,
    output logic [ttfc_pkg::DataW-1:0]    prdata,
    output logic                          pready,
    ttfc_meas_if.sink                     meas,
    ttfc_act_if.source                    act
);
    import ttfc_pkg::*;

    typedef struct packed {
        logic       issued;
        logic       auto_sel;
        logic [6:0] pct;
        logic       is_auto;
    } fan_t;

    function automatic fan_t fan_apply(fan_t f, logic en, logic signed [8:0] pct);
        fan_t r;
        r = f;
        if (en)
        begin
            r.issued = 1'b1;
            if (pct < 9'sd0)
                r.pct = 7'd0;
            else if (pct > 9'sd100)
                r.pct = 7'd100;
            else
                r.pct = pct[6:0];
            r.auto_sel = (r.pct == 7'd0);
            r.is_auto  = (r.pct == 7'd0);
        end
        return r;
    endfunction

    cfg_t cfg;

    ttfc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    logic       in_valid_reg;
    logic [7:0] temp_reg;
    logic [7:0] pwm_reg;

    // controller state
    logic        cooling_reg;
    logic        cooling_next;
    logic [13:0] sleep_reg;
    logic [13:0] sleep_next;
    logic [7:0]  prev_temp_reg;
    logic        fan_auto_reg;

    // output register
    logic        out_valid_reg;
    logic        fan_write_reg;
    logic        fan_auto_out_reg;
    logic [7:0]  fan_pwm_reg;
    logic        throttle_reg;
    logic [13:0] sleep_ms_reg;
    logic [2:0]  repeats_reg;

    logic advance;

    assign advance    = in_valid_reg && (!out_valid_reg || act.ready);
    assign meas.ready = !in_valid_reg || advance;

    // working fan level from the readback, pwm*100/255
    logic [14:0] lvl_scaled;
    logic [15:0] lvl_sum;
    logic [6:0]  lvl_base;

    assign lvl_scaled = 15'(pwm_reg) * 15'd100;
    assign lvl_sum    = 16'(lvl_scaled) + 16'(lvl_scaled >> 8) + 16'd1;
    assign lvl_base   = lvl_sum[14:8];

    logic signed [9:0] ease;
    logic              lt_ease;
    logic              gt_ease;
    logic              fixed_on;

    assign ease     = $signed({2'b00, cfg.max_temp}) - $signed({2'b00, cfg.falloff});
    assign lt_ease  = $signed({2'b00, temp_reg}) < ease;
    assign gt_ease  = $signed({2'b00, temp_reg}) > ease;
    assign fixed_on = (cfg.fixed_fan_level != 7'd0);

    fan_t              f;
    logic signed [8:0] lvl;
    logic [31:0]       div3_prod;
    logic [14:0]       grow;

    always_comb
    begin
        f            = '{issued: 1'b0, auto_sel: 1'b0, pct: 7'd0, is_auto: fan_auto_reg};
        lvl          = $signed({2'b00, lvl_base});
        cooling_next = cooling_reg;
        sleep_next   = sleep_reg;
        div3_prod    = '0;
        grow         = '0;

        if (fixed_on)
            f = fan_apply(f, cfg.fan_control_enable, $signed({2'b00, cfg.fixed_fan_level}));

        if (temp_reg > cfg.max_temp)
        begin
            if (!cooling_reg)
                sleep_next = StartSleep;
            cooling_next = 1'b1;
        end

        if (cooling_next)
        begin
            if (lt_ease)
            begin
                if (sleep_next <= StartSleep)
                begin
                    sleep_next   = 14'd0;
                    cooling_next = 1'b0;
                end
                // divide by 1.5
                div3_prod  = 32'({sleep_next, 1'b0}) * 32'(Div3Mul);
                sleep_next = div3_prod[30:17];
                if (!fixed_on)
                begin
                    if (lvl > 9'sd0)
                        lvl = lvl - 9'sd2;
                    f = fan_apply(f, cfg.fan_control_enable, lvl);
                end
            end
            else if ((prev_temp_reg < temp_reg) && gt_ease)
            begin
                // multiply by 1.5, saturating
                grow = 15'(sleep_next) + 15'(sleep_next >> 1);
                if (grow > 15'(MaxSleep))
                    sleep_next = MaxSleep;
                else
                    sleep_next = grow[13:0];
            end
        end

        if (cooling_next)
        begin
            if (!fixed_on)
            begin
                if (lvl < 9'sd100)
                    lvl = lvl + 9'sd10;
                f = fan_apply(f, cfg.fan_control_enable, lvl);
            end
        end
        else if (!fixed_on && !f.is_auto)
        begin
            if (prev_temp_reg > temp_reg)
            begin
                if (lvl > 9'sd50)
                begin
                    lvl = lvl - 9'sd2;
                    f   = fan_apply(f, cfg.fan_control_enable, lvl);
                end
                else if (lvl < 9'sd50)
                begin
                    lvl = 9'sd0;
                    f   = fan_apply(f, cfg.fan_control_enable, lvl);
                end
            end
            else
            begin
                lvl = lvl + 9'sd2;
                if (lvl > 9'sd100)
                    lvl = 9'sd100;
                f = fan_apply(f, cfg.fan_control_enable, lvl);
            end
        end
    end

    // manual duty, percent*255/100
    logic [14:0] duty_scaled;
    logic [27:0] duty_prod;

    assign duty_scaled = {f.pct, 8'd0} - 15'(f.pct);
    assign duty_prod   = 28'(duty_scaled) * 28'(Div100Mul);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cooling_reg   <= 1'b0;
            sleep_reg     <= 14'd0;
            prev_temp_reg <= 8'd0;
            fan_auto_reg  <= 1'b0;
        end
        else
        begin
            if (meas.ready)
                in_valid_reg <= meas.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (act.ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                cooling_reg   <= cooling_next;
                sleep_reg     <= sleep_next;
                prev_temp_reg <= temp_reg;
                fan_auto_reg  <= f.is_auto;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (meas.ready && meas.valid)
        begin
            temp_reg <= meas.temp_c;
            pwm_reg  <= meas.fan_pwm_in;
        end
        if (advance)
        begin
            fan_write_reg    <= f.issued;
            fan_auto_out_reg <= f.auto_sel;
            fan_pwm_reg      <= duty_prod[26:19];
            throttle_reg     <= cooling_next;
            sleep_ms_reg     <= cooling_next ? sleep_next : 14'd0;
            repeats_reg      <= cooling_next ? Pauses : 3'd0;
        end
    end

    assign act.valid         = out_valid_reg;
    assign act.fan_write     = fan_write_reg;
    assign act.fan_auto      = fan_auto_out_reg;
    assign act.fan_pwm_out   = fan_pwm_reg;
    assign act.throttle      = throttle_reg;
    assign act.sleep_ms      = sleep_ms_reg;
    assign act.pause_repeats = repeats_reg;

endmodule

// File: rtl/ttfc_regs.sv
`timescale 1ns / 1ps
// ttfc_regs: apb register file holding the controller configuration
// depends on ttfc_pkg

module ttfc_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ttfc_pkg::AddrW-1:0]    paddr,
    input  logic [ttfc_pkg::DataW-1:0]    pwdata,
    output logic [ttfc_pkg::DataW-1:0]    prdata,
    output logic                          pready,
    output ttfc_pkg::cfg_t                cfg
);
    import ttfc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                RegMaxTemp:   cfg_next.max_temp           = pwdata[7:0];
                RegFalloff:   cfg_next.falloff            = pwdata[7:0];
                RegFixedFan:  cfg_next.fixed_fan_level    = pwdata[6:0];
                RegFanEnable: cfg_next.fan_control_enable = pwdata[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_temp           <= MaxTempReset;
            cfg_reg.falloff            <= FalloffReset;
            cfg_reg.fixed_fan_level    <= 7'd0;
            cfg_reg.fan_control_enable <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            RegMaxTemp:   prdata = DataW'(cfg_reg.max_temp);
            RegFalloff:   prdata = DataW'(cfg_reg.falloff);
            RegFixedFan:  prdata = DataW'(cfg_reg.fixed_fan_level);
            RegFanEnable: prdata = DataW'(cfg_reg.fan_control_enable);
            default:      prdata = '0;
        endcase
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for thermal_throttle_fan_controller
// depends on ttfc_pkg, ttfc_if and the controller rtl; predicts every act item

module tb_top;
    import ttfc_pkg::*;

    localparam int FanStep      = 2;
    localparam int FanAutoLevel = 50;

    typedef struct packed {
        logic        fan_write;
        logic        fan_auto;
        logic [7:0]  fan_pwm_out;
        logic        throttle;
        logic [13:0] sleep_ms;
        logic [2:0]  pause_repeats;
    } fan_plan_t;

    logic             clk     = 1'b0;
    logic             rst_n   = 1'b0;
    logic             psel    = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite  = 1'b0;
    logic [AddrW-1:0] paddr   = '0;
    logic [DataW-1:0] pwdata  = '0;
    logic [DataW-1:0] prdata;
    logic             pready;

    ttfc_meas_if meas ();
    ttfc_act_if  act ();

    thermal_throttle_fan_controller DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .meas    (meas),
        .act     (act)
    );

    // shadow configuration and controller state
    cfg_t        shadow_cfg;
    logic        cooling_now;
    int          sleep_now;
    logic [7:0]  last_temp;
    logic        auto_now;

    fan_plan_t   fan_plan_q[$];
    int          mismatch_count = 0;
    int          send_idle_pct  = 37;
    int          recv_idle_pct  = 65;

    always #10 clk = ~clk;

    initial
    begin
        #(20_000_000);
        $display("Mismatches found");
        $finish;
    end

    function automatic void issue_fan(input int percent, inout fan_plan_t plan);
        if (!shadow_cfg.fan_control_enable)
            return;
        if (percent < 0)
            percent = 0;
        if (percent > 100)
            percent = 100;
        plan.fan_write = 1'b1;
        if (percent == 0)
        begin
            plan.fan_auto    = 1'b1;
            plan.fan_pwm_out = 8'd0;
            auto_now         = 1'b1;
        end
        else
        begin
            plan.fan_auto    = 1'b0;
            plan.fan_pwm_out = 8'((percent * 255) / 100);
            auto_now         = 1'b0;
        end
    endfunction

    function automatic fan_plan_t predict_fan_plan(input logic [7:0] temp_in,
                                                   input logic [7:0] pwm_in);
        fan_plan_t plan;
        int        t;
        int        last;
        int        hot;
        int        ease;
        int        level;
        int        fixed_lvl;
        plan      = '0;
        t         = int'(temp_in);
        last      = int'(last_temp);
        hot       = int'(shadow_cfg.max_temp);
        ease      = hot - int'(shadow_cfg.falloff);
        fixed_lvl = int'(shadow_cfg.fixed_fan_level);

        if (fixed_lvl > 0)
            issue_fan(fixed_lvl, plan);

        level = (int'(pwm_in) * 100) / 255;

        if (t > hot)
        begin
            if (!cooling_now)
                sleep_now = int'(StartSleep);
            cooling_now = 1'b1;
        end

        if (cooling_now)
        begin
            if (t < ease)
            begin
                if (sleep_now <= int'(StartSleep))
                begin
                    sleep_now   = 0;
                    cooling_now = 1'b0;
                end
                sleep_now = (sleep_now * 2) / 3;
                if (fixed_lvl == 0)
                begin
                    if (level > 0)
                        level -= FanStep;
                    issue_fan(level, plan);
                end
            end
            else if (last < t && t > ease)
            begin
                sleep_now = (sleep_now * 3) / 2;
                if (sleep_now > int'(MaxSleep))
                    sleep_now = int'(MaxSleep);
            end
        end

        if (cooling_now)
        begin
            if (fixed_lvl == 0)
            begin
                if (level < 100)
                    level += FanStep * 5;
                issue_fan(level, plan);
            end
        end
        else if (fixed_lvl == 0 && !auto_now)
        begin
            if (last > t)
            begin
                if (level > FanAutoLevel)
                begin
                    level -= FanStep;
                    issue_fan(level, plan);
                end
                else if (level < FanAutoLevel)
                begin
                    level = 0;
                    issue_fan(level, plan);
                end
            end
            else
            begin
                level += FanStep;
                if (level > 100)
                    level = 100;
                issue_fan(level, plan);
            end
        end

        last_temp          = temp_in;
        sleep_now          = sleep_now & 'h3FFF;
        plan.throttle      = cooling_now;
        plan.sleep_ms      = cooling_now ? 14'(sleep_now) : 14'd0;
        plan.pause_repeats = cooling_now ? Pauses : 3'd0;
        return plan;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // receiver side
    always @(negedge clk)
        act.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        fan_plan_t want;
        if (rst_n && act.valid && act.ready)
        begin
            if (fan_plan_q.size() == 0)
            begin
                $error("act item with no prediction waiting");
                mismatch_count++;
            end
            else
            begin
                want = fan_plan_q.pop_front();
                check_field("fan_write", want.fan_write, act.fan_write);
                check_field("fan_auto", want.fan_auto, act.fan_auto);
                check_field("fan_pwm_out", want.fan_pwm_out, act.fan_pwm_out);
                check_field("throttle", want.throttle, act.throttle);
                check_field("sleep_ms", want.sleep_ms, act.sleep_ms);
                check_field("pause_repeats", want.pause_repeats, act.pause_repeats);
            end
        end
    end

    // called just after a falling edge, returns just after one
    task automatic send_reading(input logic [7:0] temp_in, input logic [7:0] pwm_in);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            meas.valid <= 1'b0;
            @(negedge clk);
        end
        meas.valid      <= 1'b1;
        meas.temp_c     <= temp_in;
        meas.fan_pwm_in <= pwm_in;
        @(posedge clk);
        while (!meas.ready)
            @(posedge clk);
        fan_plan_q.push_back(predict_fan_plan(temp_in, pwm_in));
        @(negedge clk);
    endtask

    task automatic drain_results();
        meas.valid <= 1'b0;
        @(negedge clk);
        while (fan_plan_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DataW-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= AddrW'(int'(idx) * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            RegMaxTemp:   shadow_cfg.max_temp           = value[7:0];
            RegFalloff:   shadow_cfg.falloff            = value[7:0];
            RegFixedFan:  shadow_cfg.fixed_fan_level    = value[6:0];
            RegFanEnable: shadow_cfg.fan_control_enable = value[0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input int max_t, input int fall, input int fixed_lvl,
                              input int enable);
        drain_results();
        write_reg(RegMaxTemp, DataW'(max_t));
        write_reg(RegFalloff, DataW'(fall));
        write_reg(RegFixedFan, DataW'(fixed_lvl));
        write_reg(RegFanEnable, DataW'(enable));
    endtask

    task automatic reset_dut();
        meas.valid      = 1'b0;
        meas.temp_c     = '0;
        meas.fan_pwm_in = '0;
        act.ready       = 1'b0;
        shadow_cfg.max_temp           = MaxTempReset;
        shadow_cfg.falloff            = FalloffReset;
        shadow_cfg.fixed_fan_level    = '0;
        shadow_cfg.fan_control_enable = 1'b1;
        cooling_now = 1'b0;
        sleep_now   = 0;
        last_temp   = '0;
        auto_now    = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
    endtask

    task automatic test_directed();
        // heat up, sleep grows, then eases back and hands over to auto
        send_reading(8'd0, 8'd0);
        send_reading(8'd255, 8'd255);
        send_reading(8'd255, 8'd128);
        send_reading(8'd254, 8'd0);
        send_reading(8'd60, 8'd200);
        send_reading(8'd60, 8'd200);
        send_reading(8'd50, 8'd20);
        send_reading(8'd80, 8'd254);
        send_reading(8'd0, 8'd255);
        // fan writes suppressed
        set_config(75, 5, 0, 0);
        send_reading(8'd200, 8'd100);
        send_reading(8'd10, 8'd50);
        // fixed level above full scale
        set_config(75, 5, 127, 1);
        send_reading(8'd100, 8'd0);
        send_reading(8'd50, 8'd255);
        set_config(75, 5, 101, 1);
        send_reading(8'd30, 8'd30);
        set_config(75, 5, 100, 1);
        send_reading(8'd31, 8'd31);
        // falloff larger than max_temp
        set_config(10, 200, 0, 1);
        send_reading(8'd5, 8'd128);
        send_reading(8'd20, 8'd128);
        send_reading(8'd255, 8'd255);
        set_config(0, 0, 0, 1);
        send_reading(8'd0, 8'd0);
        send_reading(8'd1, 8'd255);
        set_config(255, 255, 1, 1);
        send_reading(8'd255, 8'd255);
        send_reading(8'd0, 8'd127);
        set_config(75, 5, 0, 1);
    endtask

    task automatic run_walk(input int count);
        int t;
        int pick;
        logic [7:0] pwm;
        t = int'(shadow_cfg.max_temp) - 10 + $urandom_range(0, 20);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                t = $urandom_range(0, 255);
            else
                t = t + $urandom_range(0, 14) - 7;
            if (t < 0)
                t = 0;
            if (t > 255)
                t = 255;
            pick = $urandom_range(0, 9);
            if (pick == 0)
                pwm = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            else if (pick == 1)
                pwm = 8'($urandom_range(230, 255));
            else
                pwm = 8'($urandom_range(0, 255));
            send_reading(8'(t), pwm);
        end
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct);
        int max_t;
        int fall;
        int fixed_lvl;
        int enable;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int seg = 0; seg < 6; seg++)
        begin
            if (seg == 0)
            begin
                max_t = 0;
                fall  = 255;
            end
            else if (seg == 1)
            begin
                max_t = 255;
                fall  = 0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                max_t = $urandom_range(0, 255);
                fall  = $urandom_range(0, 255);
            end
            else
            begin
                max_t = $urandom_range(40, 110);
                fall  = $urandom_range(0, 20);
            end
            fixed_lvl = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 127);
            enable    = ($urandom_range(0, 19) < 17) ? 1 : 0;
            set_config(max_t, fall, fixed_lvl, enable);
            run_walk(60);
        end
    endtask

    task automatic test_pause_until_drained();
        set_config(70, 8, 0, 1);
        run_walk(20);
        drain_results();
        run_walk(20);
    endtask

    task automatic finish_run();
        drain_results();
        for (int n = 0; n < 100000 && fan_plan_q.size() != 0; n++)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fan_plan_q.size() != 0)
        begin
            $error("%0d predicted act items never arrived", fan_plan_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    endtask

    initial
    begin
        reset_dut();
        test_directed();
        test_random_phase(37, 65);
        test_pause_until_drained();
        test_random_phase(65, 37);
        test_random_phase(0, 0);
        finish_run();
    end

endmodule
